// ===== design/pli_pkg.sv =====
`default_nettype none
package pli_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int POINT_INDEX_W = 6;
	localparam int SEGMENT_W     = 6;
	localparam int STATUS_W      = 2;
	localparam int POINT_COUNT_W = 7;
	localparam int CFG_INDEX_W   = 4;
	localparam int CFG_DATA_W    = 8;

	localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RST = 7'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POINT_COUNT = 4'd0,
		REG_CLAMP_MODE  = 4'd1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_CLAMPED    = 2'd1,
		ST_REJECTED   = 2'd2,
		ST_WRITE_DONE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_RD_FIRST,
		DP_RD_LAST,
		DP_CHECK,
		DP_SCAN,
		DP_LOAD_K0,
		DP_PREP,
		DP_SAT,
		DP_MUL,
		DP_DIV,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic reject;
		logic scan_more;
		logic trivial;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== design/pli_datapath.sv =====
`default_nettype none
module pli_datapath #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire pli_pkg::dp_cmd_t                  cmd,
	output pli_pkg::dp_sts_t                       sts,
	input  wire                                    cfg_we,
	input  wire        [pli_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire        [pli_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                                    operation,
	input  wire        [pli_pkg::POINT_INDEX_W-1:0] point_index,
	input  wire signed [DATA_WIDTH-1:0]            key,
	input  wire signed [DATA_WIDTH-1:0]            value,
	output logic signed [DATA_WIDTH-1:0]           result,
	output logic       [pli_pkg::SEGMENT_W-1:0]    segment,
	output logic       [pli_pkg::STATUS_W-1:0]     status
);

	localparam int D  = DATA_WIDTH;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = CW + 1;

	logic signed [D-1:0] key_mem [MAX_POINTS];
	logic signed [D-1:0] val_mem [MAX_POINTS];

	logic                wr_en;
	logic [AW-1:0]       rd_addr;
	logic                rd_en;
	logic signed [D-1:0] rd_key_q, rd_val_q;

	logic [pli_pkg::POINT_COUNT_W-1:0] pc_q;
	logic                              clamp_q;
	logic [CW-1:0]                     n_act;

	logic signed [D-1:0] q_q, first_q, k0_q, k1_q, v0_q, v1_q, res_q;
	logic [AW-1:0]       seg_q;
	logic [pli_pkg::STATUS_W-1:0] st_q;
	logic signed [D:0]   dk_q, dq_q, dv_q;
	logic [D-1:0]        divisor_q, mag_q;
	logic                neg_q;
	logic [2*D-1:0]      acc_q;

	logic                below, above, scan_more;
	logic [D-1:0]        dq_sat, mag;
	logic [D:0]          dv_neg;
	logic [D:0]          mul_sum, div_t, div_diff;
	logic                div_ge;
	logic [D-1:0]        div_r;

	logic signed [D-1:0]          out_result_q;
	logic [pli_pkg::SEGMENT_W-1:0] out_segment_q;
	logic [pli_pkg::STATUS_W-1:0]  out_status_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= pli_pkg::POINT_COUNT_RST;
			clamp_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == pli_pkg::REG_POINT_COUNT)
				pc_q <= cfg_data[pli_pkg::POINT_COUNT_W-1:0];
			else if (cfg_index == pli_pkg::REG_CLAMP_MODE)
				clamp_q <= cfg_data[0];
		end
	end

	always_comb begin
		if (pc_q < pli_pkg::POINT_COUNT_RST)
			n_act = CW'(2);
		else if (32'(pc_q) > MAX_POINTS)
			n_act = CW'(MAX_POINTS);
		else
			n_act = CW'(pc_q);
	end

	assign below     = q_q < first_q;
	assign above     = q_q > rd_key_q;
	assign scan_more = (SW'(seg_q) + SW'(2) < SW'(n_act)) && (rd_key_q < q_q);

	assign sts.is_query  = operation == pli_pkg::OP_QUERY;
	assign sts.reject    = (below || above) && !clamp_q;
	assign sts.scan_more = scan_more;
	assign sts.trivial   = dk_q[D] || (dk_q == '0);

	// table access
	assign wr_en = (cmd.op == pli_pkg::DP_ACCEPT) && (operation == pli_pkg::OP_WRITE)
		&& (32'(point_index) < MAX_POINTS);

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		case (cmd.op)
			pli_pkg::DP_RD_FIRST: rd_addr = '0;
			pli_pkg::DP_RD_LAST:  rd_addr = AW'(n_act - CW'(1));
			pli_pkg::DP_CHECK:    rd_addr = AW'(1);
			pli_pkg::DP_SCAN:     rd_addr = scan_more ? seg_q + AW'(2) : seg_q;
			default:              rd_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[AW'(point_index)] <= key;
			val_mem[AW'(point_index)] <= value;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	// offset saturation and magnitude
	always_comb begin
		if (dq_q[D])
			dq_sat = '0;
		else if (dq_q > dk_q)
			dq_sat = dk_q[D-1:0];
		else
			dq_sat = dq_q[D-1:0];
		dv_neg = -dv_q;
		mag    = dv_q[D] ? dv_neg[D-1:0] : dv_q[D-1:0];
	end

	// shift-add multiply and restoring divide share acc_q
	assign mul_sum  = {1'b0, acc_q[2*D-1:D]} + (acc_q[0] ? {1'b0, mag_q} : '0);
	assign div_t    = acc_q[2*D-1:D-1];
	assign div_diff = div_t - {1'b0, divisor_q};
	assign div_ge   = div_t >= {1'b0, divisor_q};
	assign div_r    = div_ge ? div_diff[D-1:0] : div_t[D-1:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			pli_pkg::DP_ACCEPT: begin
				q_q   <= key;
				seg_q <= '0;
				res_q <= '0;
				st_q  <= (operation == pli_pkg::OP_WRITE) ? pli_pkg::ST_WRITE_DONE
					: pli_pkg::ST_OK;
			end
			pli_pkg::DP_RD_LAST: first_q <= rd_key_q;
			pli_pkg::DP_CHECK: begin
				if (below || above) begin
					if (!clamp_q) begin
						res_q <= '0;
						st_q  <= pli_pkg::ST_REJECTED;
					end else begin
						q_q  <= below ? first_q : rd_key_q;
						st_q <= pli_pkg::ST_CLAMPED;
					end
				end
			end
			pli_pkg::DP_SCAN: begin
				if (scan_more) begin
					seg_q <= seg_q + AW'(1);
				end else begin
					k1_q <= rd_key_q;
					v1_q <= rd_val_q;
				end
			end
			pli_pkg::DP_LOAD_K0: begin
				k0_q <= rd_key_q;
				v0_q <= rd_val_q;
			end
			pli_pkg::DP_PREP: begin
				dk_q <= {k1_q[D-1], k1_q} - {k0_q[D-1], k0_q};
				dq_q <= {q_q[D-1], q_q} - {k0_q[D-1], k0_q};
				dv_q <= {v1_q[D-1], v1_q} - {v0_q[D-1], v0_q};
			end
			pli_pkg::DP_SAT: begin
				if (sts.trivial)
					res_q <= v0_q;
				divisor_q <= dk_q[D-1:0];
				mag_q     <= mag;
				neg_q     <= dv_q[D];
				acc_q     <= {{D{1'b0}}, dq_sat};
			end
			pli_pkg::DP_MUL: acc_q <= {mul_sum, acc_q[D-1:1]};
			pli_pkg::DP_DIV: acc_q <= {div_r, acc_q[D-2:0], div_ge};
			pli_pkg::DP_FINISH: res_q <= neg_q ? v0_q - $signed(acc_q[D-1:0])
				: v0_q + $signed(acc_q[D-1:0]);
			default: ;
		endcase
		if (cmd.load_out) begin
			out_result_q  <= res_q;
			out_segment_q <= pli_pkg::SEGMENT_W'(seg_q);
			out_status_q  <= st_q;
		end
	end

	assign result  = out_result_q;
	assign segment = out_segment_q;
	assign status  = out_status_q;

endmodule
`default_nettype wire

// ===== design/pli_controller.sv =====
`default_nettype none
module pli_controller #(
	parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	output pli_pkg::dp_cmd_t      cmd,
	input  wire pli_pkg::dp_sts_t sts
);

	localparam int CNTW = $clog2(DATA_WIDTH);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DATA_WIDTH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_CHECK,
		S_SCAN,
		S_K0,
		S_PREP,
		S_SAT,
		S_MUL,
		S_DIV,
		S_FINISH,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;
	logic            out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.op       = pli_pkg::DP_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = pli_pkg::DP_ACCEPT;
			S_FIRST:  cmd.op = pli_pkg::DP_RD_FIRST;
			S_LAST:   cmd.op = pli_pkg::DP_RD_LAST;
			S_CHECK:  cmd.op = pli_pkg::DP_CHECK;
			S_SCAN:   cmd.op = pli_pkg::DP_SCAN;
			S_K0:     cmd.op = pli_pkg::DP_LOAD_K0;
			S_PREP:   cmd.op = pli_pkg::DP_PREP;
			S_SAT:    cmd.op = pli_pkg::DP_SAT;
			S_MUL:    cmd.op = pli_pkg::DP_MUL;
			S_DIV:    cmd.op = pli_pkg::DP_DIV;
			S_FINISH: cmd.op = pli_pkg::DP_FINISH;
			S_DONE:   cmd.load_out = out_free;
			default:  cmd.op = pli_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= sts.is_query ? S_FIRST : S_DONE;
				end
				S_FIRST: state_q <= S_LAST;
				S_LAST:  state_q <= S_CHECK;
				S_CHECK: state_q <= sts.reject ? S_DONE : S_SCAN;
				S_SCAN: begin
					if (!sts.scan_more)
						state_q <= S_K0;
				end
				S_K0:   state_q <= S_PREP;
				S_PREP: state_q <= S_SAT;
				S_SAT: begin
					cnt_q   <= '0;
					state_q <= sts.trivial ? S_DONE : S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_LAST)
						state_q <= S_FINISH;
					else
						cnt_q <= cnt_q + CNTW'(1);
				end
				S_FINISH: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_write_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !sts.is_query) |=> state_q == S_DONE)
		else $error("write item did not go straight to result");

	a_reject_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && sts.reject) |=> state_q == S_DONE)
		else $error("rejected query went on to search");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && cnt_q == CNT_LAST) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("divide did not start with a cleared count");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not presented after completion");

endmodule
`default_nettype wire

// ===== design/piecewise_linear_interpolator.sv =====
// accept to result valid: a write goes straight to the result; a rejected query
// stops after the range check; a query runs a table scan, one key a cycle, up
// to the segment found, then a bit-serial multiply and divide; a zero-width
// segment skips multiply and divide; next item taken the cycle after completion
// reset clears control and sets point_count 2, clamp_mode 0; tables keep contents
`default_nettype none
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire                                     operation,
	input  wire        [pli_pkg::POINT_INDEX_W-1:0] point_index,
	input  wire signed [DATA_WIDTH-1:0]             key,
	input  wire signed [DATA_WIDTH-1:0]             value,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic signed [DATA_WIDTH-1:0]            result,
	output logic       [pli_pkg::SEGMENT_W-1:0]     segment,
	output logic       [pli_pkg::STATUS_W-1:0]      status,
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire        [pli_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire        [pli_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pli_pkg::dp_cmd_t cmd;
	pli_pkg::dp_sts_t sts;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	pli_controller #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	pli_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.point_index (point_index),
		.key         (key),
		.value       (value),
		.result      (result),
		.segment     (segment),
		.status      (status)
	);

endmodule
`default_nettype wire
